// ===== sv/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
package ple_pkg;

   typedef struct packed {
      logic [3:0]         func;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data;
      logic [6:0]         found_at;
      logic [6:0]         count;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      FN_INIT     = 4'd0,
      FN_DESTROY  = 4'd1,
      FN_CLEAR    = 4'd2,
      FN_EMPTY    = 4'd3,
      FN_LENGTH   = 4'd4,
      FN_GET      = 4'd5,
      FN_LOCATE   = 4'd6,
      FN_PRIOR    = 4'd7,
      FN_NEXT     = 4'd8,
      FN_INSERT   = 4'd9,
      FN_DELETE   = 4'd10,
      FN_TRAVERSE = 4'd11
   } ple_func_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_ERROR     = 3'd1,
      STS_BAD_POS   = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_FULL      = 3'd4
   } ple_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_TRV_RD,
      ST_TRV_WAIT,
      ST_EMIT
   } ple_state_type;

   // flags from the shared index/compare unit
   typedef struct packed {
      logic idx_eq;
      logic nx_eq;
      logic key_eq;
   } ple_scan_type;

endpackage

// ===== sv/positional_list_engine.sv =====
// Positional list engine: one ordered list of signed values with positional edits.
//
// A request (func, position, value) is taken on the req_ channel when req_valid
// is high and req_stall is low. The engine handles one request at a time and
// holds req_stall high until its last response has been handed to the output
// register; a new request is then taken while that response still waits.
// Every request answers with one response on the rsp_ channel, except a
// traverse of a non-empty list, which answers with one response per element in
// list order and sets last on the final one.
// Simple requests answer straight from decode; get reads the element once; locate
// reads and compares element by element (prior and next then read the neighbor
// when there is one); insert shifts each later element up one slot, delete reads
// the element and then shifts the later ones down; traverse reads and emits each
// element. All walks go through the single store read port and one shared
// index/compare unit.
// Reset empties the list and marks it uninitialized; store contents are not
// cleared. While rsp_stall is high the pending response holds and the
// sequencer waits before presenting the next one.
module positional_list_engine
   import ple_pkg::*;
   #(parameter int CAPACITY   = 32,
     parameter int DATA_WIDTH = 32)
   (input  logic    clock,
    input  logic    reset,
    input  logic    req_valid,
    output logic    req_stall,
    input  req_type req_data,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output rsp_type rsp_data);

   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                  slot_free;
   logic                  emit;
   rsp_type               emit_data;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;

   ple_store #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH), .ADDR_W(ADDR_W)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata));

   ple_ctrl #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH),
              .LEN_W(LEN_W), .ADDR_W(ADDR_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .slot_free (slot_free),
      .emit      (emit),
      .emit_data (emit_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata));

   // output register: free when empty or being taken this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/ple_store.sv =====
// Element store: one write port, one read port with registered read data.
module ple_store
   #(parameter int DEPTH  = 32,
     parameter int WIDTH  = 32,
     parameter int ADDR_W = 5)
   (input  logic              clock,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ple_scan.sv =====
// Shared index stepper and compare unit used by every list walk.
module ple_scan
   import ple_pkg::*;
   #(parameter int LEN_W      = 6,
     parameter int DATA_WIDTH = 32)
   (input  logic [LEN_W-1:0]      idx,
    input  logic [LEN_W-1:0]      bound,
    input  logic                  down,
    input  logic [DATA_WIDTH-1:0] elem,
    input  logic [DATA_WIDTH-1:0] key,
    output logic [LEN_W-1:0]      nx,
    output ple_scan_type          flags);

   assign nx = down ? idx - LEN_W'(1) : idx + LEN_W'(1);

   always_comb begin
      flags.idx_eq = (idx == bound);
      flags.nx_eq  = (nx == bound);
      flags.key_eq = (elem == key);
   end

endmodule

// ===== sv/ple_ctrl.sv =====
// Command sequencer: decodes a request and walks the store through the shared unit.
module ple_ctrl
   import ple_pkg::*;
   #(parameter int CAPACITY   = 32,
     parameter int DATA_WIDTH = 32,
     parameter int LEN_W      = 6,
     parameter int ADDR_W     = 5)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_type               req_data,
    input  logic                  slot_free,
    output logic                  emit,
    output rsp_type               emit_data,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_waddr,
    output logic [DATA_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [ADDR_W-1:0]     mem_raddr,
    input  logic [DATA_WIDTH-1:0] mem_rdata);

   ple_state_type         state_ff, state_in;
   ple_func_type          func_ff, func_in;
   logic [7:0]            pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [LEN_W-1:0]      idx_ff, idx_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  init_ff, init_in;
   rsp_type               res_ff, res_in;

   logic [LEN_W-1:0]      nx;
   logic [LEN_W-1:0]      idx_m1;
   logic [LEN_W-1:0]      pos_m1;
   logic [LEN_W-1:0]      bound;
   ple_scan_type          flags;
   logic [7:0]            len8;
   logic                  get_bad;
   logic                  ins_bad;
   logic                  full;
   logic                  is_insert;
   logic signed [63:0]    val_sx;
   logic signed [63:0]    key_sx;
   logic signed [63:0]    rd_sx;
   logic [31:0]           key32;
   logic [31:0]           rd32;

   assign len8      = 8'(len_ff);
   assign get_bad   = (pos_ff == 8'd0) || (pos_ff > len8);
   assign ins_bad   = (pos_ff == 8'd0) || (pos_ff > len8 + 8'd1);
   assign full      = (len_ff == LEN_W'(CAPACITY));
   assign is_insert = (func_ff == FN_INSERT);
   assign pos_m1    = LEN_W'(pos_ff - 8'd1);
   assign idx_m1    = idx_ff - LEN_W'(1);
   assign bound     = is_insert ? pos_m1 : len_ff;

   // values live at DATA_WIDTH bits, results carry the low 32 sign-extended bits
   assign val_sx = 64'(req_data.value);
   assign key_sx = 64'(signed'(key_ff));
   assign rd_sx  = 64'(signed'(mem_rdata));
   assign key32  = key_sx[31:0];
   assign rd32   = rd_sx[31:0];

   ple_scan #(.LEN_W(LEN_W), .DATA_WIDTH(DATA_WIDTH)) u_scan (
      .idx   (idx_ff),
      .bound (bound),
      .down  (is_insert),
      .elem  (mem_rdata),
      .key   (key_ff),
      .nx    (nx),
      .flags (flags));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (func_ff == FN_INIT || !init_ff) begin
               state_in = ST_EMIT;
            end else begin
               case (func_ff)
                  FN_GET, FN_DELETE: state_in = get_bad ? ST_EMIT : ST_FETCH;
                  FN_LOCATE, FN_PRIOR, FN_NEXT: begin
                     state_in = (len_ff == '0) ? ST_EMIT : ST_SCAN_RD;
                  end
                  FN_INSERT: state_in = (full || ins_bad) ? ST_EMIT : ST_MOVE_RD;
                  FN_TRAVERSE: state_in = (len_ff == '0) ? ST_EMIT : ST_TRV_RD;
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (flags.key_eq) begin
               case (func_ff)
                  FN_PRIOR: state_in = (idx_ff == '0) ? ST_EMIT : ST_FETCH;
                  FN_NEXT:  state_in = flags.nx_eq ? ST_EMIT : ST_FETCH;
                  default:  state_in = ST_EMIT;
               endcase
            end else begin
               state_in = flags.nx_eq ? ST_EMIT : ST_SCAN_RD;
            end
         end
         ST_FETCH:      state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = (func_ff == FN_DELETE) ? ST_MOVE_RD : ST_EMIT;
         ST_MOVE_RD:    state_in = flags.idx_eq ? ST_EMIT : ST_MOVE_WR;
         ST_MOVE_WR:    state_in = ST_MOVE_RD;
         ST_TRV_RD:     state_in = ST_TRV_WAIT;
         ST_TRV_WAIT:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               if (func_ff == FN_TRAVERSE && !res_ff.last) state_in = ST_TRV_RD;
               else                                        state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      func_in   = func_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      init_in   = init_ff;
      res_in    = res_ff;
      req_stall = (state_ff != ST_IDLE);
      emit      = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[ADDR_W-1:0];
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = idx_ff[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = ple_func_type'(req_data.func);
               pos_in  = req_data.position;
               key_in  = val_sx[DATA_WIDTH-1:0];
            end
         end
         ST_DECODE: begin
            res_in          = '0;
            res_in.status   = STS_OK;
            res_in.last     = 1'b1;
            if (func_ff == FN_INIT) begin
               init_in = 1'b1;
               len_in  = '0;
            end else if (!init_ff) begin
               res_in.status = STS_ERROR;
            end else begin
               case (func_ff)
                  FN_DESTROY: begin
                     len_in  = '0;
                     init_in = 1'b0;
                  end
                  FN_CLEAR:  len_in = '0;
                  FN_EMPTY:  res_in.data = 32'(len_ff == '0);
                  FN_LENGTH: res_in.data = 32'(len_ff);
                  FN_GET, FN_DELETE: begin
                     if (get_bad) res_in.status = STS_BAD_POS;
                     else         idx_in = pos_m1;
                  end
                  FN_LOCATE, FN_PRIOR, FN_NEXT: begin
                     if (len_ff == '0) res_in.status = STS_NOT_FOUND;
                     idx_in = '0;
                  end
                  FN_INSERT: begin
                     if (full)         res_in.status = STS_FULL;
                     else if (ins_bad) res_in.status = STS_BAD_POS;
                     idx_in = len_ff;
                  end
                  FN_TRAVERSE: idx_in = '0;
                  default: res_in.status = STS_ERROR;
               endcase
            end
         end
         ST_SCAN_RD, ST_FETCH, ST_TRV_RD: mem_re = 1'b1;
         ST_SCAN_CHK: begin
            if (flags.key_eq) begin
               res_in.found_at = 7'(nx);
               case (func_ff)
                  FN_PRIOR: begin
                     if (idx_ff == '0) res_in.status = STS_NOT_FOUND;
                     idx_in = idx_m1;
                  end
                  FN_NEXT: begin
                     if (flags.nx_eq) res_in.status = STS_NOT_FOUND;
                     idx_in = nx;
                  end
                  default: res_in.data = key32;
               endcase
            end else begin
               if (flags.nx_eq) res_in.status = STS_NOT_FOUND;
               idx_in = nx;
            end
         end
         ST_FETCH_WAIT: begin
            res_in.data = rd32;
            if (func_ff == FN_DELETE) idx_in = LEN_W'(pos_ff);
         end
         ST_MOVE_RD: begin
            if (flags.idx_eq) begin
               if (is_insert) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_m1[ADDR_W-1:0];
                  mem_wdata = key_ff;
                  len_in    = len_ff + LEN_W'(1);
               end else begin
                  len_in = len_ff - LEN_W'(1);
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = is_insert ? nx[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
            end
         end
         ST_MOVE_WR: begin
            // shift one element toward the opening (insert) or the gap (delete)
            mem_we    = 1'b1;
            mem_waddr = is_insert ? idx_ff[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
            idx_in    = nx;
         end
         ST_TRV_WAIT: begin
            res_in.data = rd32;
            res_in.last = flags.nx_eq;
         end
         ST_EMIT: begin
            emit = slot_free;
            if (slot_free) idx_in = nx;
         end
         default: ;
      endcase
   end

   always_comb begin
      emit_data       = res_ff;
      emit_data.count = 7'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("list length above capacity");

   a_uninit_empty: assert property (@(posedge clock) disable iff (reset)
      !init_ff |-> len_ff == '0)
      else $error("uninitialized list holds elements");

   a_len_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(len_ff)) |->
         ($past(state_ff) == ST_DECODE || $past(state_ff) == ST_MOVE_RD))
      else $error("length changed outside decode or edit completion");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_MOVE_WR || state_ff == ST_MOVE_RD))
      else $error("store written outside an edit");

endmodule

// ===== tb/positional_list_engine_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the positional list engine: directed table, then random phases.
module positional_list_engine_test;
   import ple_pkg::*;

   localparam int         LIST_CAP     = 32;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         TAIL_CYCLES  = 40;
   localparam int         HOLD_CYCLES  = 300;
   localparam logic [3:0] FN_UNUSED_LO = 4'd12;
   localparam logic [3:0] FN_UNUSED_HI = 4'd15;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   positional_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type dir_rows[$];

   // shadow copy of the list
   logic signed [31:0] list_vals [LIST_CAP];
   int                 list_len   = 0;
   bit                 list_ready = 1'b0;

   rsp_type op_rsp[$];
   rsp_type expected_rsp[$];

   int err_count     = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rx_stall_pct  = 0;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
      err_count++;
   endtask

   function automatic rsp_type mk_rsp(ple_status_type st, logic [31:0] d, int at, bit lst);
      rsp_type r;
      r.status   = st;
      r.data     = d;
      r.found_at = 7'(at);
      r.count    = 7'(list_len);
      r.last     = lst;
      return r;
   endfunction

   function automatic int find_first(logic signed [31:0] v);
      for (int k = 0; k < list_len; k++)
         if (list_vals[k] == v)
            return k + 1;
      return 0;
   endfunction

   // Fills op_rsp with the responses one request causes and updates the shadow list.
   task automatic model_list_op(req_type r);
      int                 at;
      int                 pos;
      logic signed [31:0] gone;
      op_rsp.delete();
      pos = int'(r.position);
      at  = find_first(r.value);
      if (r.func == FN_INIT) begin
         list_ready = 1'b1;
         list_len   = 0;
         op_rsp.push_back(mk_rsp(STS_OK, '0, 0, 1'b1));
      end else if (!list_ready || r.func > FN_TRAVERSE) begin
         op_rsp.push_back(mk_rsp(STS_ERROR, '0, 0, 1'b1));
      end else begin
         case (r.func)
            FN_DESTROY: begin
               list_len   = 0;
               list_ready = 1'b0;
               op_rsp.push_back(mk_rsp(STS_OK, '0, 0, 1'b1));
            end
            FN_CLEAR: begin
               list_len = 0;
               op_rsp.push_back(mk_rsp(STS_OK, '0, 0, 1'b1));
            end
            FN_EMPTY:
               op_rsp.push_back(mk_rsp(STS_OK, 32'(list_len == 0), 0, 1'b1));
            FN_LENGTH:
               op_rsp.push_back(mk_rsp(STS_OK, 32'(list_len), 0, 1'b1));
            FN_GET: begin
               if (pos < 1 || pos > list_len)
                  op_rsp.push_back(mk_rsp(STS_BAD_POS, '0, 0, 1'b1));
               else
                  op_rsp.push_back(mk_rsp(STS_OK, list_vals[pos-1], 0, 1'b1));
            end
            FN_LOCATE: begin
               if (at == 0)
                  op_rsp.push_back(mk_rsp(STS_NOT_FOUND, '0, 0, 1'b1));
               else
                  op_rsp.push_back(mk_rsp(STS_OK, r.value, at, 1'b1));
            end
            FN_PRIOR: begin
               if (at <= 1)
                  op_rsp.push_back(mk_rsp(STS_NOT_FOUND, '0, at, 1'b1));
               else
                  op_rsp.push_back(mk_rsp(STS_OK, list_vals[at-2], at, 1'b1));
            end
            FN_NEXT: begin
               if (at == 0 || at >= list_len)
                  op_rsp.push_back(mk_rsp(STS_NOT_FOUND, '0, at, 1'b1));
               else
                  op_rsp.push_back(mk_rsp(STS_OK, list_vals[at], at, 1'b1));
            end
            FN_INSERT: begin
               // full is checked ahead of the position
               if (list_len >= LIST_CAP)
                  op_rsp.push_back(mk_rsp(STS_FULL, '0, 0, 1'b1));
               else if (pos < 1 || pos > list_len + 1)
                  op_rsp.push_back(mk_rsp(STS_BAD_POS, '0, 0, 1'b1));
               else begin
                  for (int k = list_len; k >= pos; k--)
                     list_vals[k] = list_vals[k-1];
                  list_vals[pos-1] = r.value;
                  list_len++;
                  op_rsp.push_back(mk_rsp(STS_OK, '0, 0, 1'b1));
               end
            end
            FN_DELETE: begin
               if (pos < 1 || pos > list_len)
                  op_rsp.push_back(mk_rsp(STS_BAD_POS, '0, 0, 1'b1));
               else begin
                  gone = list_vals[pos-1];
                  for (int k = pos; k < list_len; k++)
                     list_vals[k-1] = list_vals[k];
                  list_len--;
                  op_rsp.push_back(mk_rsp(STS_OK, gone, 0, 1'b1));
               end
            end
            default: begin
               if (list_len == 0)
                  op_rsp.push_back(mk_rsp(STS_OK, '0, 0, 1'b1));
               else
                  for (int k = 0; k < list_len; k++)
                     op_rsp.push_back(mk_rsp(STS_OK, list_vals[k], 0, k == list_len - 1));
            end
         endcase
      end
   endtask

   task automatic add_row(logic [3:0] f, logic [7:0] pos, logic [31:0] val, bit typed,
                          ple_status_type st = STS_OK, logic [31:0] d = '0, int cnt = 0);
      stim_row_type row;
      row.req.func      = f;
      row.req.position  = pos;
      row.req.value     = val;
      row.typed         = typed;
      row.want.status   = st;
      row.want.data     = d;
      row.want.found_at = '0;
      row.want.count    = 7'(cnt);
      row.want.last     = 1'b1;
      dir_rows.push_back(row);
   endtask

   // Offers one request, honoring the sender idle rate, and logs the expected responses.
   task automatic send_request(req_type r, bit typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      model_list_op(r);
      if (typed)
         expected_rsp.push_back(want);
      else
         foreach (op_rsp[i])
            expected_rsp.push_back(op_rsp[i]);
   endtask

   function automatic req_type pick_request(int ins_w, int del_w);
      req_type r;
      int      roll;
      int      q;
      roll       = $urandom_range(99);
      q          = $urandom_range(99);
      r.value    = $urandom;
      r.position = 8'($urandom_range(255));
      if (!list_ready)
         r.func = (roll < 80) ? FN_INIT : 4'($urandom_range(15));
      else if (roll < ins_w)
         r.func = FN_INSERT;
      else if (roll < ins_w + del_w)
         r.func = FN_DELETE;
      else if (q < 18)
         r.func = FN_GET;
      else if (q < 36)
         r.func = FN_LOCATE;
      else if (q < 52)
         r.func = FN_PRIOR;
      else if (q < 68)
         r.func = FN_NEXT;
      else if (q < 75)
         r.func = FN_EMPTY;
      else if (q < 82)
         r.func = FN_LENGTH;
      else if (q < 90)
         r.func = FN_TRAVERSE;
      else if (q < 94)
         r.func = FN_CLEAR;
      else if (q < 96)
         r.func = FN_DESTROY;
      else if (q < 98)
         r.func = FN_INIT;
      else
         r.func = 4'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
      // searches mostly hit, inserts sometimes duplicate
      if (list_len > 0 &&
          ((r.func inside {FN_LOCATE, FN_PRIOR, FN_NEXT} && $urandom_range(99) < 75) ||
           (r.func == FN_INSERT && $urandom_range(99) < 25)))
         r.value = list_vals[$urandom_range(list_len - 1)];
      if ($urandom_range(99) < 85)
         r.position = 8'($urandom_range(list_len + 1, 1));
      return r;
   endfunction

   task automatic run_phase(int idle_pct, int stall_pct, int ins_w, int del_w, int items,
                            bit hold);
      send_idle_pct = idle_pct;
      rx_stall_pct <= stall_pct;
      if (hold)
         hold_token <= hold_token + 1;
      repeat (items)
         send_request(pick_request(ins_w, del_w), 1'b0, '0);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Response side: checks in order, stalls at random or for a long hold-off.
   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response with none pending", rsp_data.data, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.data !== want.data)
               report_mismatch("data", rsp_data.data, want.data);
            if (rsp_data.found_at !== want.found_at)
               report_mismatch("found_at", 32'(rsp_data.found_at), 32'(want.found_at));
            if (rsp_data.count !== want.count)
               report_mismatch("count", 32'(rsp_data.count), 32'(want.count));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** positional_list_engine: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // uninitialized list answers error
      add_row(FN_GET,       8'd1,   '0,           1'b1, STS_ERROR,   '0, 0);
      add_row(FN_TRAVERSE,  8'd0,   '0,           1'b1, STS_ERROR,   '0, 0);
      add_row(FN_UNUSED_HI, 8'hff,  32'hffffffff, 1'b1, STS_ERROR,   '0, 0);
      add_row(FN_INIT,      8'd0,   '0,           1'b1, STS_OK,      '0, 0);
      add_row(FN_EMPTY,     8'd0,   '0,           1'b1, STS_OK,      1,  0);
      add_row(FN_TRAVERSE,  8'd0,   '0,           1'b1, STS_OK,      '0, 0);
      add_row(FN_DELETE,    8'd1,   '0,           1'b1, STS_BAD_POS, '0, 0);
      add_row(FN_INSERT,    8'd0,   32'd5,        1'b1, STS_BAD_POS, '0, 0);
      add_row(FN_INSERT,    8'd1,   32'h80000000, 1'b1, STS_OK,      '0, 1);
      add_row(FN_INSERT,    8'd2,   32'h7fffffff, 1'b1, STS_OK,      '0, 2);
      add_row(FN_INSERT,    8'd4,   32'd7,        1'b1, STS_BAD_POS, '0, 2);
      add_row(FN_INSERT,    8'd1,   '0,           1'b0);
      add_row(FN_GET,       8'd0,   '0,           1'b1, STS_BAD_POS, '0, 3);
      add_row(FN_GET,       8'd255, '0,           1'b1, STS_BAD_POS, '0, 3);
      add_row(FN_GET,       8'd3,   '0,           1'b0);
      add_row(FN_LOCATE,    8'd0,   32'hffffffff, 1'b1, STS_NOT_FOUND, '0, 3);
      add_row(FN_LOCATE,    8'd0,   32'h7fffffff, 1'b0);
      add_row(FN_PRIOR,     8'd0,   '0,           1'b0);
      add_row(FN_NEXT,      8'd0,   32'h7fffffff, 1'b0);
      add_row(FN_PRIOR,     8'd0,   32'h7fffffff, 1'b0);
      add_row(FN_NEXT,      8'd0,   '0,           1'b0);
      add_row(FN_TRAVERSE,  8'd0,   '0,           1'b0);
      add_row(FN_LENGTH,    8'd0,   '0,           1'b0);
      add_row(FN_DELETE,    8'd2,   '0,           1'b0);
      add_row(FN_INIT,      8'd0,   '0,           1'b1, STS_OK,      '0, 0);
      add_row(FN_DESTROY,   8'd0,   '0,           1'b1, STS_OK,      '0, 0);
      add_row(FN_LENGTH,    8'd0,   '0,           1'b1, STS_ERROR,   '0, 0);
      add_row(FN_INIT,      8'd0,   '0,           1'b1, STS_OK,      '0, 0);
      foreach (dir_rows[i])
         send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);

      run_phase(0,  0,  45, 15, 70, 1'b0);
      run_phase(72, 0,  80, 5,  70, 1'b0);   // fill toward full
      run_phase(0,  72, 30, 30, 70, 1'b0);
      run_phase(12, 12, 35, 35, 70, 1'b0);
      run_phase(0,  0,  40, 20, 40, 1'b1);   // long receiver hold-off
      run_phase(0,  0,  10, 70, 50, 1'b0);   // drain

      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("** positional_list_engine: PASSED **");
      else
         $display("** positional_list_engine: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ple_pkg.sv
sv/ple_store.sv
sv/ple_scan.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
tb/positional_list_engine_test.sv
